@@ rtl/gha_pkg.sv @@
`default_nettype none

package gha_pkg;

  // Default sizing
  localparam int CAPACITY_DEF     = 1024;
  localparam int VERSION_BITS_DEF = 16;

  // Port field widths
  localparam int MODE_W   = 2;
  localparam int HIDX_W   = 10;
  localparam int HVER_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 11;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

`default_nettype wire

@@ rtl/generational_handle_allocator.sv @@
`default_nettype none

// Generational handle allocator. Each request (allocate, release, check) passes three
// stages: the free-stack pop read at the accepting edge, the version-table read at the
// chosen slot, then the version-table and stack write-back, which loads the result into
// the output register once that register is free to take it. Because of these two dependent
// synchronous memory reads, only one request is in flight at a time; a new request is taken
// as soon as the previous one has written back, even while its result still waits on
// out_stall. There is no clearing pass after reset: data read from either memory is used
// only after that entry has been written.
// Allocate returns status pool full once every slot is live.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [HIDX_W-1:0]   handle_index,
  input  wire logic [HVER_W-1:0]   handle_version,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [HIDX_W-1:0]   out_index,
  output logic      [HVER_W-1:0]   out_version,
  output logic      [LIVE_W-1:0]   live_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VB    = VERSION_BITS;
  localparam int CMP_W = (VB > HVER_W) ? VB : HVER_W;
  localparam int IXW_W = IDX_W + HIDX_W;
  localparam int LC_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_VRD  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0]        state;
  logic [MODE_W-1:0] req_mode;
  logic [HIDX_W-1:0] req_idx;
  logic [HVER_W-1:0] req_ver;
  logic [IDX_W-1:0]  slot;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  used_slots;

  logic              accept;
  logic              commit;
  logic              pop;
  logic [CNT_W-1:0]  cnt_dec;
  logic [IXW_W-1:0]  hidx_wide;
  logic [IDX_W-1:0]  hidx;
  logic [IDX_W-1:0]  vt_raddr;

  logic [IDX_W-1:0]  stk_rdata;
  logic [VB:0]       vt_rdata;
  logic [VB-1:0]     vt_ver;
  logic              vt_live;
  logic              handle_ok;
  logic [VB-1:0]     bump;

  logic              vt_we;
  logic [IDX_W-1:0]  vt_waddr;
  logic [VB:0]       vt_wdata;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;

  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    oidx_next;
  logic [VB-1:0]       over_next;
  logic [CNT_W-1:0]    free_next;
  logic [CNT_W-1:0]    used_next;
  logic [IXW_W-1:0]    oidx_wide;
  logic [CMP_W-1:0]    over_wide;
  logic [LC_W-1:0]     live_wide;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == S_EXE) && (!out_valid || !out_stall);

  assign cnt_dec   = free_count - CNT_W'(1);
  assign hidx_wide = IXW_W'(req_idx);
  assign hidx      = hidx_wide[IDX_W-1:0];
  assign pop       = (req_mode == MODE_ALLOC) && (free_count != '0);
  assign vt_raddr  = pop ? stk_rdata : hidx;

  gha_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack (
    .clk   (clk),
    .we    (stk_we && commit),
    .waddr (stk_waddr),
    .wdata (slot),
    .re    (accept),
    .raddr (cnt_dec[IDX_W-1:0]),
    .rdata (stk_rdata)
  );

  gha_ram #(.WIDTH(VB + 1), .DEPTH(CAPACITY)) u_vtab (
    .clk   (clk),
    .we    (vt_we && commit),
    .waddr (vt_waddr),
    .wdata (vt_wdata),
    .re    (state == S_VRD),
    .raddr (vt_raddr),
    .rdata (vt_rdata)
  );

  assign vt_ver    = vt_rdata[VB-1:0];
  assign vt_live   = vt_rdata[VB];
  assign handle_ok = (32'(req_idx) < 32'(used_slots)) && vt_live &&
                     (CMP_W'(vt_ver) == CMP_W'(req_ver));
  assign bump      = ((vt_ver + VB'(1)) == '0) ? VB'(1) : (vt_ver + VB'(1));

  always_comb begin
    status_next = ST_INVALID;
    oidx_next   = '0;
    over_next   = '0;
    free_next   = free_count;
    used_next   = used_slots;
    vt_we       = 1'b0;
    vt_waddr    = slot;
    vt_wdata    = '0;
    stk_we      = 1'b0;
    stk_waddr   = free_count[IDX_W-1:0];
    unique case (req_mode)
      MODE_ALLOC: begin
        if (free_count != '0) begin
          // Reuse the popped slot at its current version
          vt_we       = 1'b1;
          vt_wdata    = {1'b1, vt_ver};
          free_next   = cnt_dec;
          status_next = ST_OK;
          oidx_next   = slot;
          over_next   = vt_ver;
        end else if (used_slots < CNT_W'(CAPACITY)) begin
          vt_we       = 1'b1;
          vt_waddr    = used_slots[IDX_W-1:0];
          vt_wdata    = {1'b1, VB'(1)};
          used_next   = used_slots + CNT_W'(1);
          status_next = ST_OK;
          oidx_next   = used_slots[IDX_W-1:0];
          over_next   = VB'(1);
        end else begin
          status_next = ST_FULL;
        end
      end
      MODE_RELEASE: begin
        if (handle_ok && (free_count < CNT_W'(CAPACITY))) begin
          vt_we       = 1'b1;
          vt_wdata    = {1'b0, bump};
          stk_we      = 1'b1;
          free_next   = free_count + CNT_W'(1);
          status_next = ST_OK;
        end
      end
      MODE_CHECK: begin
        status_next = handle_ok ? ST_OK : ST_INVALID;
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  assign oidx_wide = IXW_W'(oidx_next);
  assign over_wide = CMP_W'(over_next);
  assign live_wide = LC_W'(used_next - free_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      used_slots <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_VRD;
          end
        end
        S_VRD: begin
          state <= S_EXE;
        end
        S_EXE: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        free_count <= free_next;
        used_slots <= used_next;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_idx  <= handle_index;
      req_ver  <= handle_version;
    end
    if (state == S_VRD) begin
      slot <= vt_raddr;
    end
    if (commit) begin
      status      <= status_next;
      out_index   <= oidx_wide[HIDX_W-1:0];
      out_version <= over_wide[HVER_W-1:0];
      live_count  <= live_wide[LIVE_W-1:0];
    end
  end

  // Free slots are always a subset of slots ever handed out
  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_count <= used_slots)
    else $error("free stack deeper than used slots");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_VRD) ##1 (state == S_EXE))
    else $error("request did not advance through read stages");

  a_result_from_exe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXE))
    else $error("result produced outside write-back");

  a_counts_move_once: assert property (@(posedge clk) disable iff (rst)
    !$stable(free_count) |-> ($stable(used_slots) && $past(commit)))
    else $error("free and used counts changed together or outside commit");

  a_used_grow: assert property (@(posedge clk) disable iff (rst)
    !$stable(used_slots) |-> (used_slots == $past(used_slots) + CNT_W'(1)))
    else $error("used slot count moved by other than one");

endmodule

`default_nettype wire

@@ rtl/gha_ram.sv @@
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
